>>> rtl/bdq_pkg.sv
// Shared constants and types for the bounded deque with search.
// Holds field widths, the default depth and the command codes.
// No dependencies.
package bdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CMD_W     = 3;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_SEARCH     = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_t;

endpackage

>>> rtl/bdq_store.sv
// Circular value store: one write port, one read port with registered data.
// Uses bdq_pkg for the value width.
module bdq_store #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [bdq_pkg::VAL_W-1:0]      wr_data,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [bdq_pkg::VAL_W-1:0]      rd_data
);

	logic [bdq_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic [bdq_pkg::VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/bounded_deque_with_search_unit.sv
// Bounded deque of signed 32-bit words with a front-first linear search.
// Insert, remove, clear and unused commands: applied and the result registered once the output is free.
// Search: entries are read from the front and compared in turn until a hit or the last entry;
// an empty store finishes at once. The next word is taken back in idle. A held result delays the next.
// Reset (arst_n low, asynchronous): store empty, front at slot 0, no result pending;
// stored entries are not cleared.
module bounded_deque_with_search_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bdq_pkg::CMD_W-1:0]        command,
	input  logic signed [bdq_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             status,
	output logic                             found,
	output logic [bdq_pkg::POS_W-1:0]        position,
	output logic [bdq_pkg::CNT_W-1:0]        count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                      state_q;
	bdq_pkg::cmd_t               cmd_q;
	logic [bdq_pkg::VAL_W-1:0]   key_q;
	logic [IW-1:0]               front_q;
	logic [CW-1:0]               occ_q;
	logic [CW-1:0]               rd_idx_q;
	logic                        cmp_valid_s1;
	logic [IW-1:0]               cmp_idx_s1;
	logic                        hit_q;
	logic [IW-1:0]               hit_pos_q;
	logic                        out_valid_q;
	logic                        status_q;
	logic                        found_q;
	logic [bdq_pkg::POS_W-1:0]   position_q;
	logic [bdq_pkg::CNT_W-1:0]   count_q;

	logic                        full;
	logic                        empty;
	logic                        slot_free;
	logic [IW-1:0]               front_dec;
	logic [IW-1:0]               front_inc;
	logic [IW-1:0]               back_slot;
	logic [IW-1:0]               rd_slot;
	logic [IW-1:0]               front_nxt;
	logic [CW-1:0]               occ_nxt;
	logic                        err;
	logic                        wr_en;
	logic [IW-1:0]               wr_addr;
	logic                        rd_en;
	logic [bdq_pkg::VAL_W-1:0]   rd_data;
	logic                        hit;
	logic                        scan_miss;
	logic                        exec_done;
	logic                        finish_done;
	logic [31:0]                 occ_ext;
	logic [31:0]                 cnt_ext;
	logic [31:0]                 pos_ext;

	function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign slot_free = !out_valid_q || !out_stall;
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
	assign back_slot = wrap_add(front_q, occ_q);
	assign rd_slot   = wrap_add(front_q, rd_idx_q);

	always_comb begin
		front_nxt = front_q;
		occ_nxt   = occ_q;
		err       = 1'b0;
		case (cmd_q)
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					err = 1'b1;
				end else begin
					front_nxt = front_dec;
					occ_nxt   = occ_q + CW'(1);
				end
			end
			bdq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					err = 1'b1;
				end else begin
					occ_nxt = occ_q + CW'(1);
				end
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					front_nxt = front_inc;
					occ_nxt   = occ_q - CW'(1);
				end
			end
			bdq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					occ_nxt = occ_q - CW'(1);
				end
			end
			bdq_pkg::CMD_CLEAR: begin
				front_nxt = '0;
				occ_nxt   = '0;
			end
			default: begin
			end
		endcase
	end

	assign exec_done   = (state_q == ST_EXEC) && (cmd_q != bdq_pkg::CMD_SEARCH) && slot_free;
	assign finish_done = (state_q == ST_FINISH) && slot_free;
	assign wr_en       = exec_done && !full &&
	                     ((cmd_q == bdq_pkg::CMD_PUSH_FRONT) || (cmd_q == bdq_pkg::CMD_PUSH_BACK));
	assign wr_addr     = (cmd_q == bdq_pkg::CMD_PUSH_FRONT) ? front_dec : back_slot;
	assign rd_en       = (state_q == ST_SCAN) && (rd_idx_q != occ_q);
	assign hit         = cmp_valid_s1 && (rd_data == key_q);
	assign scan_miss   = cmp_valid_s1 && !hit && (rd_idx_q == occ_q);

	bdq_store #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (key_q),
		.rd_en   (rd_en),
		.rd_addr (rd_slot),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			front_q      <= '0;
			occ_q        <= '0;
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (exec_done || finish_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q == bdq_pkg::CMD_SEARCH) begin
						rd_idx_q     <= '0;
						cmp_valid_s1 <= 1'b0;
						hit_q        <= 1'b0;
						if (empty) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end else if (slot_free) begin
						front_q <= front_nxt;
						occ_q   <= occ_nxt;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					cmp_valid_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (scan_miss) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign occ_ext = 32'(occ_nxt);
	assign cnt_ext = 32'(occ_q);
	assign pos_ext = 32'(hit_pos_q);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			cmd_q <= bdq_pkg::cmd_t'(command);
			key_q <= value;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[IW-1:0];
		end
		if ((state_q == ST_SCAN) && hit) begin
			hit_pos_q <= cmp_idx_s1;
		end
		if (exec_done) begin
			status_q   <= err;
			found_q    <= 1'b0;
			position_q <= '0;
			count_q    <= occ_ext[bdq_pkg::CNT_W-1:0];
		end else if (finish_done) begin
			status_q   <= 1'b0;
			found_q    <= hit_q;
			position_q <= hit_q ? pos_ext[bdq_pkg::POS_W-1:0] : '0;
			count_q    <= cnt_ext[bdq_pkg::CNT_W-1:0];
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign position  = position_q;
	assign count     = count_q;

endmodule

>>> tb/tb_bounded_deque_with_search_unit.sv
// Testbench for bounded_deque_with_search_unit: directed and random command words under varied idling,
// checked against a behavioral deque model kept in a scoreboard class.
// Depends on bdq_pkg and the unit's RTL only.
module tb_bounded_deque_with_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH       = bdq_pkg::DEPTH_DEF;
	localparam int          CMD_W       = bdq_pkg::CMD_W;
	localparam int          VAL_W       = bdq_pkg::VAL_W;
	localparam int          POS_W       = bdq_pkg::POS_W;
	localparam int          CNT_W       = bdq_pkg::CNT_W;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int          DRAIN_WAIT  = 40;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic             status;
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] count;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [VAL_W-1:0] store [DEPTH];
		logic [POS_W-1:0]        head;
		logic [CNT_W-1:0]        fill;
		deque_result_t           expected_q [$];
		int                      errors;

		function new();
			head   = '0;
			fill   = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic signed [VAL_W-1:0] pick_stored(logic signed [VAL_W-1:0] fallback);
			logic [POS_W-1:0] slot;
			if (fill == 0)
				return fallback;
			slot = head + POS_W'($urandom_range(0, fill - 1));
			return store[slot];
		endfunction

		function void note_word(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
			deque_result_t    r;
			logic [POS_W-1:0] slot;
			r = '0;
			case (cmd)
				bdq_pkg::CMD_PUSH_FRONT: begin
					if (fill == DEPTH) begin
						r.status = 1'b1;
					end else begin
						head = head - 1'b1;
						store[head] = val;
						fill++;
					end
				end
				bdq_pkg::CMD_PUSH_BACK: begin
					if (fill == DEPTH) begin
						r.status = 1'b1;
					end else begin
						slot = head + fill[POS_W-1:0];
						store[slot] = val;
						fill++;
					end
				end
				bdq_pkg::CMD_POP_FRONT: begin
					if (fill == 0) begin
						r.status = 1'b1;
					end else begin
						head = head + 1'b1;
						fill--;
					end
				end
				bdq_pkg::CMD_POP_BACK: begin
					if (fill == 0)
						r.status = 1'b1;
					else
						fill--;
				end
				bdq_pkg::CMD_SEARCH: begin
					for (int i = 0; i < fill; i++) begin
						slot = head + POS_W'(i);
						if (!r.found && store[slot] == val) begin
							r.found    = 1'b1;
							r.position = POS_W'(i);
						end
					end
				end
				bdq_pkg::CMD_CLEAR: begin
					fill = '0;
					head = '0;
				end
				default: ;
			endcase
			r.count = fill;
			expected_q.push_back(r);
		endfunction

		function void check_result(deque_result_t got);
			deque_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected, status %0d found %0d position %0d count %0d",
					$time, got.status, got.found, got.position, got.count);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d", $time, exp_r.status, got.status);
				errors++;
			end
			if (got.found !== exp_r.found) begin
				$display("%0t: found mismatch, expected %0d actual %0d", $time, exp_r.found, got.found);
				errors++;
			end
			if (got.position !== exp_r.position) begin
				$display("%0t: position mismatch, expected %0d actual %0d",
					$time, exp_r.position, got.position);
				errors++;
			end
			if (got.count !== exp_r.count) begin
				$display("%0t: count mismatch, expected %0d actual %0d", $time, exp_r.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        command   = '0;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    status;
	logic                    found;
	logic [POS_W-1:0]        position;
	logic [CNT_W-1:0]        count;

	int unsigned     tx_idle_pct  = 0;
	int unsigned     rx_stall_pct = 0;
	int unsigned     cycle_count  = 0;
	deque_scoreboard sb           = new();

	bounded_deque_with_search_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found     (found),
		.position  (position),
		.count     (count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({status, found, position, count});
	end

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(cmd, val);
	endtask

	task automatic random_word(input bit filling);
		int unsigned             r;
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < (filling ? 65 : 15))
			cmd = ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
		else if (r < 80)
			cmd = ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
		else if (r < 96)
			cmd = bdq_pkg::CMD_SEARCH;
		else if (r < 97)
			cmd = bdq_pkg::CMD_CLEAR;
		else
			cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
		case ($urandom_range(0, 4))
			0, 1: val = $signed($urandom_range(0, 7)) - 4;
			2: val = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
			default: val = $urandom;
		endcase
		if (cmd == bdq_pkg::CMD_SEARCH && $urandom_range(0, 9) < 6)
			val = sb.pick_stored(val);
		send_word(cmd, val);
	endtask

	initial begin
		bit filling;
		int n;
		int blk;
		filling = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(bdq_pkg::CMD_SEARCH, '0);
		send_word(bdq_pkg::CMD_POP_FRONT, VAL_MAX);
		send_word(bdq_pkg::CMD_POP_BACK, VAL_MIN);
		send_word(bdq_pkg::CMD_PUSH_FRONT, VAL_MIN);
		send_word(bdq_pkg::CMD_PUSH_BACK, VAL_MAX);
		send_word(bdq_pkg::CMD_PUSH_FRONT, -32'sd1);
		send_word(bdq_pkg::CMD_PUSH_BACK, '0);
		for (int i = 1; i <= 11; i++)
			send_word(bdq_pkg::CMD_PUSH_BACK, i);
		send_word(bdq_pkg::CMD_PUSH_BACK, 32'sh1234_5678);
		send_word(bdq_pkg::CMD_PUSH_FRONT, 32'sh0f0f_0f0f);
		send_word(bdq_pkg::CMD_PUSH_BACK, 32'sh7070_7070);
		send_word(bdq_pkg::CMD_SEARCH, 32'sh1234_5678);
		send_word(bdq_pkg::CMD_SEARCH, VAL_MAX);
		send_word(bdq_pkg::CMD_SEARCH, 32'sh0bad_cafe);
		send_word(CMD_SPARE_6, -32'sd1);
		send_word(CMD_SPARE_7, '0);
		send_word(bdq_pkg::CMD_POP_FRONT, '0);
		send_word(bdq_pkg::CMD_POP_BACK, '0);
		send_word(bdq_pkg::CMD_CLEAR, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
				default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
			endcase
			n = 0;
			while (n < 215) begin
				blk = $urandom_range(20, 50);
				filling = ~filling;
				repeat (blk) begin
					random_word(filling);
					n++;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
rtl/bdq_pkg.sv
rtl/bdq_store.sv
rtl/bounded_deque_with_search_unit.sv
tb/tb_bounded_deque_with_search_unit.sv
